/* hdl/mts_pkg.sv */
// shared types and constants for the min tracking stack
`timescale 1ns / 1ps

package mts_pkg;

  // command codes
  typedef enum logic [1:0] {
    CMD_PUSH   = 2'd0,
    CMD_POP    = 2'd1,
    CMD_PEEK   = 2'd2,
    CMD_GETMIN = 2'd3
  } cmd_t;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // value returned by peek on an empty stack
  localparam logic signed [31:0] PEEK_EMPTY_VALUE = 32'sd777;

  // configuration register map
  localparam logic REG_CAPACITY = 1'b0;
  localparam logic [4:0] CAPACITY_RESET = 5'd16;

  // one stack slot: the word and the minimum of it and everything below
  typedef struct packed {
    logic signed [31:0] val;
    logic signed [31:0] min;
  } entry_t;

endpackage

/* hdl/min_tracking_stack.sv */
// top level of the min tracking stack: command decode, slot memory and config port
`timescale 1ns / 1ps

// Bounded LIFO of signed 32-bit words that also reports the minimum it holds.
// Request channel: in_cmd / in_data are taken at a rising edge where start is
// high and busy is low. busy stays low: one request is taken every cycle.
// Result channel: out_status / out_value are shown for exactly one cycle with
// out_strobe high, in the cycle after the request was taken. The receiver cannot
// stall, so results are never held back.
// Each slot memory entry stores a word and the running minimum of that word and
// all words below it, so every command touches only the top of the stack.
// The current top is held in a register after a push; after a pop the new top
// comes from the registered read of the slot memory issued with the pop, which
// is ready in time for the very next request.
// Config: APB register 0 (byte address 0) is capacity, 5 bits, reset 16.
// Capacity above DEPTH acts as DEPTH; capacity 0 makes every push report full.
// Reset (rst_n low, synchronous) empties the stack and restores capacity; the
// slot memory needs no clearing pass since only filled slots are ever read.

module min_tracking_stack #(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  // request channel
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_cmd,
  input  logic signed [31:0] in_data,
  // result channel
  output logic               out_strobe,
  output logic [1:0]         out_status,
  output logic signed [31:0] out_value,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CMPW = (CW > 5) ? CW : 5;

  // slot memory
  mts_pkg::entry_t mem [DEPTH];

  logic [CW-1:0]      count_r, count_nxt;
  logic [4:0]         cap_r;
  logic               sel_mem_r, sel_mem_nxt;
  mts_pkg::entry_t    top_r, top_nxt;
  mts_pkg::entry_t    rd_data_r;
  logic               out_strobe_r;
  logic [1:0]         out_status_r, out_status_nxt;
  logic signed [31:0] out_value_r, out_value_nxt;

  logic               acc;
  logic               cfg_wr;
  mts_pkg::cmd_t      cmd;
  mts_pkg::entry_t    top_ent;
  mts_pkg::entry_t    wr_ent;
  logic               is_empty;
  logic               is_full;
  logic               wr_en;
  logic               rd_en;
  logic [CW-1:0]      below_top;
  logic [AW-1:0]      wr_addr;
  logic [AW-1:0]      rd_addr;

  // handshake
  assign busy   = 1'b0;
  assign acc    = start && !busy;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  // register read back
  assign prdata = (paddr[2] == mts_pkg::REG_CAPACITY) ? 32'(cap_r) : '0;

  // current top: register after push, memory read data after pop
  assign top_ent  = sel_mem_r ? rd_data_r : top_r;
  assign is_empty = (count_r == '0);
  assign is_full  = (CMPW'(count_r) >= CMPW'(cap_r)) || (count_r >= CW'(DEPTH));
  assign cmd      = mts_pkg::cmd_t'(in_cmd);

  // slot addresses
  assign below_top = count_r - CW'(2);
  assign wr_addr   = count_r[AW-1:0];
  assign rd_addr   = below_top[AW-1:0];

  // command decode
  always_comb begin
    count_nxt      = count_r;
    sel_mem_nxt    = sel_mem_r;
    top_nxt        = top_r;
    out_status_nxt = mts_pkg::ST_OK;
    out_value_nxt  = '0;
    wr_en          = 1'b0;
    rd_en          = 1'b0;
    wr_ent.val     = in_data;
    wr_ent.min     = (!is_empty && (top_ent.min < in_data)) ? top_ent.min : in_data;
    if (acc) begin
      case (cmd)
        mts_pkg::CMD_PUSH: begin
          if (is_full) begin
            out_status_nxt = mts_pkg::ST_FULL;
          end else begin
            wr_en       = 1'b1;
            top_nxt     = wr_ent;
            sel_mem_nxt = 1'b0;
            count_nxt   = count_r + CW'(1);
          end
        end
        mts_pkg::CMD_POP: begin
          if (is_empty) begin
            out_status_nxt = mts_pkg::ST_EMPTY;
          end else begin
            count_nxt   = count_r - CW'(1);
            sel_mem_nxt = 1'b1;
            rd_en       = (count_r > CW'(1));
          end
        end
        mts_pkg::CMD_PEEK: begin
          if (is_empty) begin
            out_status_nxt = mts_pkg::ST_EMPTY;
            out_value_nxt  = mts_pkg::PEEK_EMPTY_VALUE;
          end else begin
            out_value_nxt = top_ent.val;
          end
        end
        mts_pkg::CMD_GETMIN: begin
          if (is_empty) begin
            out_status_nxt = mts_pkg::ST_EMPTY;
          end else begin
            out_value_nxt = top_ent.min;
          end
        end
        default: begin
          out_status_nxt = mts_pkg::ST_OK;
        end
      endcase
    end
  end

  // slot memory write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_ent;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      sel_mem_r    <= 1'b0;
      cap_r        <= mts_pkg::CAPACITY_RESET;
      out_strobe_r <= 1'b0;
    end else begin
      count_r      <= count_nxt;
      sel_mem_r    <= sel_mem_nxt;
      out_strobe_r <= acc;
      if (cfg_wr && (paddr[2] == mts_pkg::REG_CAPACITY)) begin
        cap_r <= pwdata[4:0];
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    top_r        <= top_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_status = out_status_r;
  assign out_value  = out_value_r;

  // every accepted request gives a result in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> out_strobe)
    else $error("request without result");

  // fill count never passes the memory depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("fill count beyond depth");

  // a refused push leaves the stack unchanged
  a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && (cmd == mts_pkg::CMD_PUSH) && is_full) |=> (count_r == $past(count_r)))
    else $error("full push changed the stack");

  // full status only answers a push
  a_full_is_push: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_status == mts_pkg::ST_FULL)) |->
      ($past(in_cmd) == mts_pkg::CMD_PUSH))
    else $error("full status on a non-push");

  // running minimum of the top never exceeds the top word
  a_min_order: assert property (@(posedge clk) disable iff (!rst_n)
    !is_empty |-> (top_ent.min <= top_ent.val))
    else $error("top minimum above top word");

endmodule
